@@ src/pfe_pkg.sv @@
// shared types and constants of the postfix expression evaluator
package pfe_pkg;

  localparam int DATA_W          = 32;
  localparam int CHAR_W          = 8;
  localparam int STATUS_W        = 2;
  localparam int STACK_DEPTH_DEF = 128;

  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [DATA_W-1:0]   word_t;

  // character codes
  localparam char_t CH_0     = 8'h30;
  localparam char_t CH_9     = 8'h39;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_COMMA = 8'h2c;
  localparam char_t CH_PLUS  = 8'h2b;
  localparam char_t CH_MINUS = 8'h2d;
  localparam char_t CH_STAR  = 8'h2a;
  localparam char_t CH_SLASH = 8'h2f;

  // status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;
  localparam status_t ST_DIVZERO   = 2'd3;

  // divider request and response
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quotient;
  } div_rsp_t;

endpackage

@@ src/pfe_if.sv @@
// stream interfaces for characters in and results out
interface pfe_in_if import pfe_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t char_code;
  logic  end_of_expr;

  modport source (output valid, output char_code, output end_of_expr, input ready);
  modport sink   (input valid, input char_code, input end_of_expr, output ready);
endinterface

interface pfe_out_if import pfe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  status_t            status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

@@ src/pfe_ram.sv @@
// generic single-write, single-read ram with registered read data
module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/pfe_div.sv @@
// iterative signed divider, one quotient bit per cycle, truncates toward zero
module pfe_div import pfe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(DATA_W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  word_t         rem_r;
  word_t         quo_r;
  word_t         dvs_r;
  logic          neg_r;

  word_t         a_abs;
  word_t         b_abs;
  logic [DATA_W:0] trial;
  logic          fits;

  assign a_abs = req.dividend[DATA_W-1] ? -req.dividend : req.dividend;
  assign b_abs = req.divisor[DATA_W-1]  ? -req.divisor  : req.divisor;
  assign trial = {rem_r, quo_r[DATA_W-1]} - {1'b0, dvs_r};
  assign fits  = ~trial[DATA_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= a_abs;
      dvs_r <= b_abs;
      neg_r <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
    end else if (busy_r) begin
      rem_r <= fits ? trial[DATA_W-1:0] : {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};
      quo_r <= {quo_r[DATA_W-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -quo_r : quo_r;

endmodule

@@ src/postfix_expression_evaluator_top.sv @@
// top level of the postfix expression evaluator: sequencer, stack ram and divider
//
// Evaluates a postfix expression fed one ASCII character per input transaction.
// Digits push their value, + - * / combine the two top entries, anything else is
// skipped. The transaction flagged end_of_expr produces one output transaction
// (top of stack, or 0 if empty, plus the sticky status) and then clears the stack
// and status. One item is handled at a time: a digit or a skipped character is
// handled in the idle state, + - * pass through an execute state, after a read
// state when the second operand comes from the stack ram read port (registered
// read data), and / by a nonzero divisor starts the 32-step bit-serial divider
// from the execute state and waits for its done (a zero divisor finishes like
// + - *). A last character then loads the output register, waiting while the
// previous result has not been taken. The stack lives in a STACK_DEPTH x 32 ram;
// the top entry is mirrored in a register so only the second operand needs a ram
// read.
module postfix_expression_evaluator_top import pfe_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  pfe_in_if.sink       in_ch,
  pfe_out_if.source    out_ch
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  // keep the first error of an expression
  function automatic status_t flag_err(status_t cur, status_t code);
    flag_err = (cur == ST_OK) ? code : cur;
  endfunction

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  status_t          status_r, status_nxt;
  word_t            tos_r, tos_nxt;       // copy of the top stack entry
  word_t            rhs_r, rhs_nxt;
  word_t            lhs_r, lhs_nxt;
  char_t            op_r, op_nxt;
  logic             last_r, last_nxt;
  logic [CNT_W-1:0] base_r, base_nxt;     // stack slot the result goes to
  logic             out_valid_r, out_valid_nxt;
  word_t            out_value_r, out_value_nxt;
  status_t          out_status_r, out_status_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  word_t            ram_wdata;
  logic [AW-1:0]    ram_raddr;
  word_t            ram_rdata;

  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic             in_fire;
  logic             is_digit;
  logic             is_op;
  logic [CNT_W-1:0] cnt_m2;
  word_t            res;
  char_t            digit_val;

  pfe_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // character classes
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_digit    = (in_ch.char_code >= CH_0) && (in_ch.char_code <= CH_9);
  assign is_op       = (in_ch.char_code == CH_PLUS) || (in_ch.char_code == CH_MINUS) ||
                       (in_ch.char_code == CH_STAR) || (in_ch.char_code == CH_SLASH);
  assign digit_val   = in_ch.char_code - CH_0;
  assign cnt_m2      = count_r - CNT_W'(2);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    tos_nxt        = tos_r;
    rhs_nxt        = rhs_r;
    lhs_nxt        = lhs_r;
    op_nxt         = op_r;
    last_nxt       = last_r;
    base_nxt       = base_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[AW-1:0];
    ram_wdata      = DATA_W'(digit_val);
    ram_raddr      = cnt_m2[AW-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = lhs_r;
    div_req.divisor  = rhs_r;
    res            = '0;

    // output register drains independently
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          last_nxt = in_ch.end_of_expr;
          op_nxt   = in_ch.char_code;
          if (is_digit) begin
            if (count_r < CNT_W'(STACK_DEPTH)) begin
              ram_we    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              tos_nxt   = DATA_W'(digit_val);
            end else begin
              // full stack, push dropped
              status_nxt = flag_err(status_r, ST_OVERFLOW);
            end
            state_nxt = in_ch.end_of_expr ? S_EMIT : S_IDLE;
          end else if (is_op) begin
            rhs_nxt = (count_r != '0) ? tos_r : '0;
            if (count_r < CNT_W'(2)) begin
              // one or both pops hit an empty stack
              status_nxt = flag_err(status_r, ST_UNDERFLOW);
              lhs_nxt    = '0;
              base_nxt   = '0;
              state_nxt  = S_EXEC;
            end else begin
              base_nxt  = cnt_m2;
              state_nxt = S_READ;
            end
          end else begin
            state_nxt = in_ch.end_of_expr ? S_EMIT : S_IDLE;
          end
        end
      end
      S_READ: begin
        lhs_nxt   = ram_rdata;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (op_r)
          CH_PLUS:  res = lhs_r + rhs_r;
          CH_MINUS: res = lhs_r - rhs_r;
          CH_STAR:  res = lhs_r * rhs_r;
          default:  res = '0;
        endcase
        if ((op_r == CH_SLASH) && (rhs_r != '0)) begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          if (op_r == CH_SLASH) begin
            status_nxt = flag_err(status_r, ST_DIVZERO);
          end
          ram_we    = 1'b1;
          ram_waddr = base_r[AW-1:0];
          ram_wdata = res;
          count_nxt = base_r + CNT_W'(1);
          tos_nxt   = res;
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          ram_we    = 1'b1;
          ram_waddr = base_r[AW-1:0];
          ram_wdata = div_rsp.quotient;
          count_nxt = base_r + CNT_W'(1);
          tos_nxt   = div_rsp.quotient;
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        // wait for a free output register, then clear for the next expression
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = (count_r != '0) ? tos_r : '0;
          out_status_nxt = status_r;
          count_nxt      = '0;
          status_nxt     = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    tos_r        <= tos_nxt;
    rhs_r        <= rhs_nxt;
    lhs_r        <= lhs_nxt;
    op_r         <= op_nxt;
    last_r       <= last_nxt;
    base_r       <= base_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = $signed(out_value_r);
  assign out_ch.status = out_status_r;

endmodule

@@ verif/tb_postfix_expression_evaluator_top.sv @@
// self-checking testbench of the postfix expression evaluator top level
`timescale 1ns / 100ps

module tb_postfix_expression_evaluator_top;
  import pfe_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int DEPTH          = STACK_DEPTH_DEF;
  localparam int PHASE_ITEMS    = 200;   // characters per phase
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either channel
  localparam int DRAIN_CYCLES   = 60;    // longer than one division plus the output load

  // one character on its way into the block
  typedef struct {
    char_t code;
    logic  last;
  } char_item_t;

  // what the block reports for one finished expression
  typedef struct {
    word_t   value;
    status_t status;
  } expr_result_t;

  logic clk;
  logic rst_n;

  pfe_in_if  in_ch ();
  pfe_out_if out_ch ();

  postfix_expression_evaluator_top #(
    .STACK_DEPTH (DEPTH)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #CLK_HALF clk = ~clk;

  // stimulus and scoreboard storage
  char_item_t   chars_to_send [$];
  expr_result_t results_due [$];

  // shadow copy of the evaluator state
  word_t       shadow_stack [DEPTH];
  int unsigned shadow_used;
  status_t     shadow_status;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned phase_items;
  int unsigned fail_count;
  int unsigned idle_cycles;
  logic        char_accepted;

  // ---------------------------------------------------------------------------
  // shadow evaluator
  // ---------------------------------------------------------------------------

  function automatic bit is_digit(input char_t ch);
    return ch >= CH_0 && ch <= CH_9;
  endfunction

  function automatic bit is_operator(input char_t ch);
    return ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH;
  endfunction

  // first error of an expression sticks
  function automatic void note_error(input status_t code);
    if (shadow_status == ST_OK) shadow_status = code;
  endfunction

  function automatic void push_operand(input word_t v);
    if (shadow_used >= DEPTH) begin
      note_error(ST_OVERFLOW);
    end else begin
      shadow_stack[shadow_used] = v;
      shadow_used++;
    end
  endfunction

  function automatic word_t pop_operand();
    if (shadow_used == 0) begin
      note_error(ST_UNDERFLOW);
      return '0;
    end
    shadow_used--;
    return shadow_stack[shadow_used];
  endfunction

  // 32-bit wrapped arithmetic, division truncating toward zero
  function automatic word_t combine(input char_t op, input word_t lhs, input word_t rhs);
    longint num;
    longint den;
    longint quo;
    case (op)
      CH_PLUS:  return lhs + rhs;
      CH_MINUS: return lhs - rhs;
      CH_STAR:  return lhs * rhs;
      default: begin
        if (rhs == '0) begin
          note_error(ST_DIVZERO);
          return '0;
        end
        // widened so that the most negative value over -1 wraps cleanly
        num = $signed(lhs);
        den = $signed(rhs);
        quo = num / den;
        return quo[31:0];
      end
    endcase
  endfunction

  // applies one character; returns 1 when it closes an expression
  function automatic bit evaluate_char(input char_t ch, input logic last,
                                       output expr_result_t res);
    word_t rhs;
    word_t lhs;
    if (is_digit(ch)) begin
      push_operand(word_t'(ch - CH_0));
    end else if (is_operator(ch)) begin
      rhs = pop_operand();
      lhs = pop_operand();
      push_operand(combine(ch, lhs, rhs));
    end
    res.value  = (shadow_used != 0) ? shadow_stack[shadow_used-1] : '0;
    res.status = shadow_status;
    if (last) begin
      shadow_used   = 0;
      shadow_status = ST_OK;
    end
    return last;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  task automatic add_char(input char_t ch, input logic last);
    char_item_t item;
    item.code = ch;
    item.last = last;
    chars_to_send.push_back(item);
    phase_items++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(char_t'(s[i]), i == s.len() - 1);
  endtask

  function automatic char_t random_digit();
    return char_t'(CH_0 + $urandom_range(9));
  endfunction

  function automatic char_t random_operator();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // separator or any character the block skips
  function automatic char_t random_filler();
    char_t ch;
    case ($urandom_range(2))
      0:       ch = CH_SPACE;
      1:       ch = CH_COMMA;
      default: begin
        do ch = char_t'($urandom_range(255)); while (is_digit(ch) || is_operator(ch));
      end
    endcase
    return ch;
  endfunction

  // closes an expression either on its last real character or on a trailing filler
  task automatic end_expr();
    if ($urandom_range(3) == 0) add_char(random_filler(), 1'b1);
    else chars_to_send[chars_to_send.size()-1].last = 1'b1;
  endtask

  // well-formed expression with random operands, operators and separators
  task automatic add_balanced_expr();
    int unsigned operands;
    int unsigned pushed;
    int unsigned depth;
    operands = $urandom_range(1, 8);
    pushed   = 0;
    depth    = 0;
    while (pushed < operands || depth > 1) begin
      if (pushed < operands && (depth < 2 || $urandom_range(1) == 0)) begin
        add_char(random_digit(), 1'b0);
        pushed++;
        depth++;
      end else begin
        add_char(random_operator(), 1'b0);
        depth--;
      end
      if ($urandom_range(3) == 0) add_char(random_filler(), 1'b0);
    end
    end_expr();
  endtask

  // long product runs push the value through 32-bit wraparound
  task automatic add_product_chain();
    int unsigned steps;
    steps = $urandom_range(4, 14);
    add_char(random_digit(), 1'b0);
    for (int i = 0; i < steps; i++) begin
      add_char(random_digit(), 1'b0);
      case ($urandom_range(4))
        0:       add_char(CH_PLUS, 1'b0);
        1:       add_char(CH_MINUS, 1'b0);
        default: add_char(CH_STAR, 1'b0);
      endcase
    end
    end_expr();
  endtask

  // random soup, mostly underflow and mixed errors
  task automatic add_broken_expr();
    int unsigned len;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(2))
        0:       add_char(random_digit(), 1'b0);
        1:       add_char(random_operator(), 1'b0);
        default: add_char(random_filler(), 1'b0);
      endcase
    end
    end_expr();
  endtask

  // 8^10 * 2 wraps to the most negative value, then divided or multiplied by -1
  task automatic add_most_negative_by_minus_one();
    add_char(char_t'(CH_0 + 8), 1'b0);
    for (int i = 0; i < 9; i++) begin
      add_char(char_t'(CH_0 + 8), 1'b0);
      add_char(CH_STAR, 1'b0);
    end
    add_char(char_t'(CH_0 + 2), 1'b0);
    add_char(CH_STAR, 1'b0);
    add_text("01-");
    chars_to_send[chars_to_send.size()-1].last = 1'b0;
    add_char($urandom_range(1) ? CH_SLASH : CH_STAR, 1'b0);
    end_expr();
  endtask

  // fills the stack past its depth, then keeps operating on the full stack
  task automatic add_overflow_expr();
    int unsigned pushes;
    int unsigned ops;
    pushes = DEPTH + $urandom_range(1, 4);
    ops    = $urandom_range(0, 3);
    for (int i = 0; i < pushes; i++) add_char(random_digit(), 1'b0);
    for (int i = 0; i < ops; i++) add_char(random_operator(), 1'b0);
    end_expr();
  endtask

  task automatic add_random_expression();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55)      add_balanced_expr();
    else if (pick < 68) add_product_chain();
    else if (pick < 82) add_broken_expr();
    else if (pick < 92) add_char(random_filler(), 1'b1);  // empty stack at the end
    else                add_most_negative_by_minus_one();
  endtask

  // one traffic phase: set the idle mix, queue the expressions, let them drain
  task automatic run_phase(input int unsigned send_pct, input int unsigned stall_pct,
                           input bit with_overflow);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    phase_items    = 0;
    if (with_overflow) add_overflow_expr();
    while (phase_items < PHASE_ITEMS) add_random_expression();
    while (chars_to_send.size() != 0 || in_ch.valid) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // character driver: changes inputs on the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin : char_driver
    char_item_t item;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || char_accepted) begin
      // current character taken (or none pending): offer the next one or idle
      if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item = chars_to_send.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.char_code   <= item.code;
        in_ch.end_of_expr <= item.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    // result side stalls at random
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor, scoreboard and watchdog: sample on the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_monitor
    expr_result_t due;
    expr_result_t got;
    bit           closes;
    if (!rst_n) begin
      char_accepted <= 1'b0;
      idle_cycles   <= 0;
    end else begin
      char_accepted <= in_ch.valid && in_ch.ready;

      // result transaction: compare with the oldest expected result
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result value %0d status %0d", $time,
                   out_ch.value, out_ch.status);
          fail_count++;
        end else begin
          due = results_due.pop_front();
          if (word_t'(out_ch.value) !== due.value) begin
            $display("%0t: value mismatch: expected %0d actual %0d", $time,
                     $signed(due.value), out_ch.value);
            fail_count++;
          end
          if (out_ch.status !== due.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time,
                     due.status, out_ch.status);
            fail_count++;
          end
        end
      end

      // character transaction: advance the shadow evaluator
      if (in_ch.valid && in_ch.ready) begin
        closes = evaluate_char(in_ch.char_code, in_ch.end_of_expr, got);
        if (closes) results_due.push_back(got);
      end

      // watchdog on cycles with no transaction at all
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.char_code   = '0;
    in_ch.end_of_expr = 1'b0;
    out_ch.ready      = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    fail_count        = 0;
    phase_items       = 0;
    shadow_used       = 0;
    shadow_status     = ST_OK;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, every operator, the divide-by-zero and underflow errors
    add_char(8'h00, 1'b0);
    add_char(8'hff, 1'b0);
    add_text("34+");      // plain sum, skipped extremes in front
    add_text("19-");      // negative difference
    add_text("99*");
    add_text("07-2/");    // negative dividend truncates toward zero
    add_text("5,0/+");    // divide by zero first, underflow after: first error kept
    add_text("+");        // pop from empty stack
    add_text(" ");        // empty stack at the end, last flag on a skipped character

    run_phase(0, 0, 1'b0);    // back to back
    run_phase(51, 0, 1'b1);   // sender gaps
    run_phase(0, 51, 1'b1);   // receiver stalls
    run_phase(16, 16, 1'b0);  // both

    while (results_due.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
